// ----- rtl/core/lfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, widths and constants for the Legendre forward recurrence.
// ----------------------------------------------------------------------------
package lfr_pkg;

    // Recurrence limits and fixed-point format
    localparam int MAX_DEGREE = 63;
    localparam int FRAC_BITS  = 30;

    // Port field widths
    localparam int VAL_W       = 32;
    localparam int DEG_FIELD_W = 6;

    // Internal widths derived from the format
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int COEF_W = DEG_W + 1;
    localparam int T1_W   = PROD_W + COEF_W;
    localparam int T2M_W  = MAG_W + DEG_W;
    localparam int T2_W   = T2M_W + FRAC_BITS;
    localparam int NUM_W  = T1_W + 2;
    localparam int DIVD_W = NUM_W - FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    // 1.0 and -1.0 in the value format
    localparam logic signed [VAL_W-1:0] ONE_VAL     = VAL_W'(64'd1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] NEG_ONE_VAL = -ONE_VAL;
    localparam logic [MAG_W-1:0]        ONE_MAG     = MAG_W'(64'd1 << FRAC_BITS);

    // Input transaction payload
    typedef struct packed {
        logic signed [VAL_W-1:0]   x_value;
        logic [DEG_FIELD_W-1:0]    top_degree;
    } lfr_in_t;

    // Result transaction payload
    typedef struct packed {
        logic [DEG_FIELD_W-1:0]    degree;
        logic signed [VAL_W-1:0]   poly_value;
        logic                      last_flag;
    } lfr_out_t;

    // Numerator pipeline step selected by the sequencer
    typedef enum logic [2:0] {
        NS_HOLD,
        NS_MUL,
        NS_SCALE,
        NS_COMB,
        NS_BIAS
    } lfr_num_step_t;

    typedef struct packed {
        lfr_num_step_t      step;
        logic [DEG_W-1:0]   l;
    } lfr_num_ctrl_t;

    // Magnitude of a value-format number, |v| <= 1.0
    function automatic logic [MAG_W-1:0] val_mag(input logic signed [VAL_W-1:0] v);
        logic [VAL_W-1:0] a;
        a = v[VAL_W-1] ? (~v + 1'b1) : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/core/lfr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_divider
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module lfr_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lfr_pkg::DIVD_W-1:0]  dividend,
    input  logic [lfr_pkg::DEG_W-1:0]   divisor,
    output logic                        done,
    output logic [lfr_pkg::DIVD_W-1:0]  quotient
);
    import lfr_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [DEG_W-1:0]    rem_reg, rem_next;
    logic [DEG_W-1:0]    dvsr_reg;

    logic [DEG_W:0]      trial;
    logic [DEG_W:0]      diff;
    logic                fits;

    // One trial subtraction per cycle
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        diff     = trial - {1'b0, dvsr_reg};
        fits     = (trial >= {1'b0, dvsr_reg});
        quo_next = {quo_reg[DIVD_W-2:0], fits};
        rem_next = fits ? diff[DEG_W-1:0] : trial[DEG_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/lfr_numerator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_numerator
// Registered steps forming |(2l+1) x P_l - l P_{l-1} 2^F| plus rounding bias.
// ----------------------------------------------------------------------------
module lfr_numerator (
    input  logic                              aclk,
    input  lfr_pkg::lfr_num_ctrl_t            ctrl,
    input  logic signed [lfr_pkg::VAL_W-1:0]  x_val,
    input  logic signed [lfr_pkg::VAL_W-1:0]  cur_val,
    input  logic signed [lfr_pkg::VAL_W-1:0]  prev_val,
    output logic [lfr_pkg::DIVD_W-1:0]        dividend,
    output logic                              neg
);
    import lfr_pkg::*;

    logic [PROD_W-1:0]       prod_reg;
    logic [T2M_W-1:0]        t2m_reg;
    logic [T1_W-1:0]         t1_reg;
    logic                    s1_reg, s2_reg;
    logic signed [NUM_W-1:0] u_reg;
    logic [DIVD_W-1:0]       dividend_reg;
    logic                    neg_reg;

    logic [MAG_W-1:0]        x_m, cur_m, prev_m;
    logic [COEF_W-1:0]       coef;
    logic [T2_W-1:0]         t2_full;
    logic signed [NUM_W-1:0] t1_ext, t2_ext;
    logic                    u_neg;
    logic [NUM_W-1:0]        bias;
    logic [NUM_W-1:0]        biased;

    always_comb begin
        x_m     = val_mag(x_val);
        cur_m   = val_mag(cur_val);
        prev_m  = val_mag(prev_val);
        coef    = {ctrl.l, 1'b1};
        t2_full = {t2m_reg, {FRAC_BITS{1'b0}}};
        t1_ext  = $signed(NUM_W'(t1_reg));
        t2_ext  = $signed(NUM_W'(t2_full));
        u_neg   = u_reg[NUM_W-1];
        // (l+1) * 2^(F-1): half the divisor, for round half away from zero
        bias    = (NUM_W'(ctrl.l) + NUM_W'(1)) << (FRAC_BITS - 1);
        // |u| + bias in one adder: invert and carry in when negative
        biased  = (u_neg ? ~u_reg : u_reg) + bias + NUM_W'(u_neg);
    end

    always_ff @(posedge aclk) begin
        case (ctrl.step)
            NS_MUL: begin
                prod_reg <= x_m * cur_m;
                t2m_reg  <= prev_m * ctrl.l;
                s1_reg   <= x_val[VAL_W-1] ^ cur_val[VAL_W-1];
                s2_reg   <= prev_val[VAL_W-1];
            end
            NS_SCALE: begin
                t1_reg <= prod_reg * coef;
            end
            NS_COMB: begin
                // numerator = s1 ? -u : u
                u_reg <= (s1_reg == s2_reg) ? (t1_ext - t2_ext) : (t1_ext + t2_ext);
            end
            NS_BIAS: begin
                neg_reg      <= s1_reg ^ u_neg;
                dividend_reg <= biased[NUM_W-1:FRAC_BITS];
            end
            default: begin
            end
        endcase
    end

    assign dividend = dividend_reg;
    assign neg      = neg_reg;

endmodule

// ----- rtl/core/legendre_forward_recurrence_top.sv -----
`timescale 1ns / 1ps
// P_0 (1.0) and P_1 (x) are emitted straight from registers, with no division.
// Each further degree passes through one output load, 4 numerator steps, one divider
// start, and the serial divider (41 quotient bits, then its done strobe).
// A new item is accepted only once the last degree of the series is loaded for output;
// an output stall holds back every degree, so it also delays the next item.
// Reset (aresetn low, synchronous) clears the sequencer, divider control and output valid.
// ----------------------------------------------------------------------------
// legendre_forward_recurrence_top
// Emits P_0(x)..P_top(x) in Q1.30 by Bonnet's recurrence with a shared divider.
// ----------------------------------------------------------------------------
module legendre_forward_recurrence_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lfr_pkg::lfr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lfr_pkg::lfr_out_t m_data
);
    import lfr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MUL,
        ST_SCALE,
        ST_COMB,
        ST_BIAS,
        ST_START,
        ST_DIV
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic signed [VAL_W-1:0] prev_reg, prev_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [DEG_W-1:0]        deg_reg, deg_next;
    logic [DEG_W-1:0]        top_reg, top_next;
    logic                    m_valid_reg, m_valid_next;
    lfr_out_t                m_data_reg, m_data_next;

    lfr_num_ctrl_t           num_ctrl;
    logic [DIVD_W-1:0]       dividend;
    logic                    num_neg;
    logic                    div_start;
    logic                    div_done;
    logic [DIVD_W-1:0]       quotient;
    logic [DEG_W-1:0]        divisor;
    logic [MAG_W-1:0]        q_mag;
    logic signed [VAL_W-1:0] q_val;
    logic signed [VAL_W-1:0] x_clamped;
    logic [DEG_W-1:0]        top_sat;

    // Numerator steps follow the sequencer state
    always_comb begin
        num_ctrl.l = deg_reg;
        case (state_reg)
            ST_MUL:   num_ctrl.step = NS_MUL;
            ST_SCALE: num_ctrl.step = NS_SCALE;
            ST_COMB:  num_ctrl.step = NS_COMB;
            ST_BIAS:  num_ctrl.step = NS_BIAS;
            default:  num_ctrl.step = NS_HOLD;
        endcase
    end

    lfr_numerator u_numerator (
        .aclk     (aclk),
        .ctrl     (num_ctrl),
        .x_val    (x_reg),
        .cur_val  (cur_reg),
        .prev_val (prev_reg),
        .dividend (dividend),
        .neg      (num_neg)
    );

    assign div_start = (state_reg == ST_START);
    assign divisor   = deg_reg + 1'b1;

    lfr_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Saturate quotient to 1.0 and apply sign
    always_comb begin
        q_mag = (quotient > DIVD_W'(ONE_MAG)) ? ONE_MAG : quotient[MAG_W-1:0];
        q_val = num_neg ? -$signed(VAL_W'(q_mag)) : $signed(VAL_W'(q_mag));
    end

    // Input clamping
    always_comb begin
        if (s_data.x_value > ONE_VAL) begin
            x_clamped = ONE_VAL;
        end else if (s_data.x_value < NEG_ONE_VAL) begin
            x_clamped = NEG_ONE_VAL;
        end else begin
            x_clamped = s_data.x_value;
        end
        if (32'(s_data.top_degree) > MAX_DEGREE) begin
            top_sat = DEG_W'(MAX_DEGREE);
        end else begin
            top_sat = DEG_W'(s_data.top_degree);
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        val_next     = val_reg;
        deg_next     = deg_reg;
        top_next     = top_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = x_clamped;
                    top_next   = top_sat;
                    deg_next   = '0;
                    val_next   = ONE_VAL;
                    cur_next   = ONE_VAL;
                    prev_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.degree     = DEG_FIELD_W'(deg_reg);
                    m_data_next.poly_value = val_reg;
                    m_data_next.last_flag  = (deg_reg == top_reg);
                    if (deg_reg != '0) begin
                        prev_next = cur_reg;
                        cur_next  = val_reg;
                    end
                    if (deg_reg == top_reg) begin
                        state_next = ST_IDLE;
                    end else if (deg_reg == '0) begin
                        deg_next = DEG_W'(1);
                        val_next = x_reg;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_COMB;
            ST_COMB:  state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    val_next   = q_val;
                    deg_next   = deg_reg + 1'b1;
                    state_next = ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        val_reg    <= val_next;
        deg_reg    <= deg_next;
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_p0_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degree == '0) |-> (m_data.poly_value == ONE_VAL && m_data.last_flag == (top_reg == '0) || state_reg != ST_IDLE || m_data.poly_value == ONE_VAL))
        else $error("degree zero result is not 1.0");

    a_value_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.poly_value <= ONE_VAL && m_data.poly_value >= NEG_ONE_VAL))
        else $error("result outside [-1, 1]");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data.degree)))
        else $error("pending result overwritten");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Legendre forward recurrence. A short table of
// directed argument/degree requests is followed by random ones. In the
// table, arguments at or beyond +/-1 and a lone P_0 have their series typed
// in. Every other series comes from a bit-exact Bonnet recurrence model kept
// here. The sender idles in bursts, the receiver stalls on a rotating
// pattern, and each result transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import lfr_pkg::*;

    localparam int      N_DIRECTED   = 20;
    localparam int      N_RANDOM     = 250;
    localparam int      QUIET_LIMIT  = 3000;   // cycles with no transaction at all
    localparam int      TAIL_CYCLES  = 120;    // idle cycles after the last result drains
    localparam longint  SCALE        = longint'(1) << FRAC_BITS;

    // One stimulus row; known rows carry their expected even/odd degree values
    typedef struct packed {
        logic signed [VAL_W-1:0]  x_value;
        logic [DEG_FIELD_W-1:0]   top_degree;
        logic                     known;
        logic signed [VAL_W-1:0]  even_value;
        logic signed [VAL_W-1:0]  odd_value;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // top degree zero: a lone P_0
        '{32'sh4000_0000, 6'd0,  1'b1, ONE_VAL, ONE_VAL},
        '{32'sh0000_0000, 6'd0,  1'b1, ONE_VAL, ONE_VAL},
        // x = +1 and x = -1 over the full degree range
        '{32'sh4000_0000, 6'd63, 1'b1, ONE_VAL, ONE_VAL},
        '{32'shC000_0000, 6'd63, 1'b1, ONE_VAL, NEG_ONE_VAL},
        // out-of-range arguments clamp to +/-1
        '{32'sh7FFF_FFFF, 6'd10, 1'b1, ONE_VAL, ONE_VAL},
        '{32'sh8000_0000, 6'd10, 1'b1, ONE_VAL, NEG_ONE_VAL},
        '{32'sh4000_0001, 6'd5,  1'b1, ONE_VAL, ONE_VAL},
        '{32'shBFFF_FFFF, 6'd5,  1'b1, ONE_VAL, NEG_ONE_VAL},
        '{32'sh5555_5555, 6'd2,  1'b1, ONE_VAL, ONE_VAL},
        '{32'shAAAA_AAAA, 6'd3,  1'b1, ONE_VAL, NEG_ONE_VAL},
        // interior arguments, checked against the model
        '{32'sh0000_0000, 6'd63, 1'b0, '0, '0},
        '{32'sh0000_0001, 6'd20, 1'b0, '0, '0},
        '{32'shFFFF_FFFF, 6'd20, 1'b0, '0, '0},
        '{32'sh3FFF_FFFF, 6'd63, 1'b0, '0, '0},
        '{32'shC000_0001, 6'd63, 1'b0, '0, '0},
        '{32'sh2000_0000, 6'd12, 1'b0, '0, '0},
        '{32'shE000_0000, 6'd12, 1'b0, '0, '0},
        '{32'sh2AAA_AAAB, 6'd1,  1'b0, '0, '0},
        '{32'sh3FFF_0000, 6'd40, 1'b0, '0, '0},
        '{32'sh3504_F334, 6'd63, 1'b0, '0, '0}
    };

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    lfr_in_t    s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    lfr_out_t   m_data;

    stim_row_t  offered_row = '0;      // row behind the current s_data
    lfr_out_t   pending_values [$];    // polynomial values still owed by the block

    int unsigned error_count    = 0;
    int unsigned requests_taken = 0;
    int unsigned clamped_taken  = 0;
    int unsigned full_top_taken = 0;
    int unsigned values_checked = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned burst_left     = 0;

    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned ready_tick    = 0;

    legendre_forward_recurrence_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // P_{l+1} from P_l and P_{l-1}: exact numerator, round half away, saturate
    function automatic longint bonnet_next(input longint x, input longint cur,
                                           input longint prev, input int l);
        logic signed [127:0] wx, wc, wp, wk, wl, num;
        logic [127:0]        mag, d, q, r;
        longint              res;
        wx  = x;
        wc  = cur;
        wp  = prev;
        wk  = 2 * l + 1;
        wl  = l;
        num = wx * wc * wk - ((wp * wl) <<< FRAC_BITS);
        mag = (num < 0) ? -num : num;
        d   = 128'(l + 1) << FRAC_BITS;
        q   = mag / d;
        r   = mag % d;
        if (q >= 128'(SCALE))
            mag = 128'(SCALE);
        else
            mag = q + ((r >= d - r) ? 128'd1 : 128'd0);
        res = longint'(mag[63:0]);
        return (num < 0) ? -res : res;
    endfunction

    // Queue the whole series P_0..P_top for one request
    function automatic void predict_legendre_series(input lfr_in_t item);
        longint   x, cur, prev, v;
        int       top;
        lfr_out_t r;
        x    = longint'(signed'(item.x_value));
        top  = int'(item.top_degree);
        prev = 0;
        cur  = SCALE;
        if (x > SCALE) x = SCALE;
        if (x < -SCALE) x = -SCALE;
        if (top > MAX_DEGREE) top = MAX_DEGREE;
        for (int l = 0; l <= top; l++) begin
            if (l == 0) v = SCALE;
            else if (l == 1) v = x;
            else v = bonnet_next(x, cur, prev, l - 1);
            if (l >= 1) begin
                prev = cur;
                cur  = v;
            end
            r.degree     = DEG_FIELD_W'(l);
            r.poly_value = VAL_W'(v);
            r.last_flag  = (l == top);
            pending_values.push_back(r);
        end
    endfunction

    // Series with values read straight off the table row
    function automatic void queue_known_series(input stim_row_t row);
        lfr_out_t r;
        for (int l = 0; l <= int'(row.top_degree); l++) begin
            r.degree     = DEG_FIELD_W'(l);
            r.poly_value = (l % 2 == 1) ? row.odd_value : row.even_value;
            r.last_flag  = (l == int'(row.top_degree));
            pending_values.push_back(r);
        end
    endfunction

    // Present one request; bursts of back-to-back transactions, gaps between
    task automatic offer_request(input stim_row_t row);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 50)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data      <= {row.x_value, row.top_degree};
        offered_row <= row;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every owed value has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_values.size() != 0);
        @(posedge aclk);
    endtask

    // Receiver stalls on a rotating 16-bit pattern that is redrawn at random, sometimes as all ones
    always @(posedge aclk) begin
        if (ready_tick % 64 == 0)
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
        m_ready <= ready_pattern[ready_tick % 16];
        ready_tick++;
    end

    // Scoreboard: queue on request transactions, check result transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                requests_taken++;
                if (s_data.x_value > ONE_VAL || s_data.x_value < NEG_ONE_VAL)
                    clamped_taken++;
                if (s_data.top_degree == DEG_FIELD_W'(MAX_DEGREE))
                    full_top_taken++;
                if (offered_row.known)
                    queue_known_series(offered_row);
                else
                    predict_legendre_series(s_data);
            end
            if (m_valid && m_ready) begin
                if (pending_values.size() == 0) begin
                    $error("unexpected result: degree %0d, poly_value %0d",
                           m_data.degree, m_data.poly_value);
                    error_count++;
                end else begin
                    automatic lfr_out_t want = pending_values.pop_front();
                    values_checked++;
                    if (m_data.degree !== want.degree) begin
                        $error("degree: expected %0d, actual %0d",
                               want.degree, m_data.degree);
                        error_count++;
                    end
                    if (m_data.poly_value !== want.poly_value) begin
                        $error("poly_value (degree %0d): expected %0d, actual %0d",
                               want.degree, want.poly_value, m_data.poly_value);
                        error_count++;
                    end
                    if (m_data.last_flag !== want.last_flag) begin
                        $error("last_flag (degree %0d): expected %0b, actual %0b",
                               want.degree, want.last_flag, m_data.last_flag);
                        error_count++;
                    end
                end
            end
            // watchdog
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("legendre_forward_recurrence_top: mismatch");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t row;
        longint    xr;
        int        pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            offer_request(DIRECTED_ROWS[i]);
        wait_drained();

        // random requests, mostly short series
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                xr = longint'($urandom_range(0, 32'h8000_0000)) - SCALE;
            end else if (pick < 8) begin
                // close to +/-1, where rounding can push past one
                xr = SCALE - longint'($urandom_range(0, 4095));
                if ($urandom_range(0, 1) == 1) xr = -xr;
            end else begin
                xr = longint'(signed'($urandom));
            end
            row            = '0;
            row.x_value    = VAL_W'(xr);
            row.top_degree = ($urandom_range(0, 4) == 0)
                             ? DEG_FIELD_W'($urandom_range(0, 63))
                             : DEG_FIELD_W'($urandom_range(0, 12));
            offer_request(row);
            if (i == N_RANDOM / 2)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d with x outside [-1,1], %0d to degree 63)",
                 requests_taken, clamped_taken, full_top_taken);
        $display("checked %0d polynomial values in order, %0d errors",
                 values_checked, error_count);
        if (error_count == 0 && pending_values.size() == 0)
            $display("legendre_forward_recurrence_top: match");
        else
            $display("legendre_forward_recurrence_top: mismatch");
        $finish;
    end

endmodule
